// ===== design/cbrs_pkg.sv =====
// package: types, constants and helpers for the rotating complex bf16 scaler
package cbrs_pkg;

  localparam logic [15:0] QnanBf16 = 16'h7FC0;
  localparam int unsigned TdataW = 32;

  // term classes after decode
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_FIN  = 2'd1,
    KIND_INF  = 2'd2,
    KIND_NAN  = 2'd3
  } kind_e;

  // one decoded and scaled term: value = mant * 2^(expo - 134)
  typedef struct packed {
    kind_e      kind;
    logic       sign;
    logic [7:0] mant;
    logic [8:0] expo;  // biased exponent plus factor magnitude, 1..255
  } term_t;

  // decode a bf16 pattern and apply a power-of-two factor with sign flip
  function automatic term_t scale_term(logic [15:0] x, logic mag, logic neg);
    term_t t;
    t.sign = x[15] ^ neg;
    t.mant = {1'b1, x[6:0]};
    t.expo = {1'b0, x[14:7]} + {8'd0, mag};
    if (x[14:7] == 8'hFF) begin
      t.kind = (x[6:0] != 7'd0) ? KIND_NAN : KIND_INF;
    end else if (x[14:7] == 8'd0) begin
      t.kind = KIND_ZERO;
    end else begin
      t.kind = KIND_FIN;
    end
    return t;
  endfunction

endpackage

// ===== design/complex_bf16_rotating_scale.sv =====
// top level: complex bf16 sample times rotating factor 2+j1, -1+j2, -2-j1, 1-j2
//
// channel | dir | tdata (low bit up)             | tuser | tlast
// s_axis  | in  | in_real[15:0], in_imag[31:16]  | -     | tile_end
// m_axis  | out | out_real[15:0], out_imag[31:16]| -     | out_tile_end
//
// one item per cycle unless m_axis stalls, three register stages (decode/scale,
// align/add, normalize/round), the last one driving m_axis.
// the tile phase is a two-bit counter, cleared by reset, advanced on
// acceptance of an item with tlast high.
// a stall on m_axis freezes every stage; s_axis tready follows whether the
// pipe can move, so no item is lost or repeated.
module complex_bf16_rotating_scale
  import cbrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,   // in_real, in_imag
  input  logic              s_axis_tlast,   // tile_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,   // out_real, out_imag
  output logic              m_axis_tlast    // out_tile_end
);

  // stage 1 regs: scaled terms
  logic [1:0] phase_q, phase_d;
  logic       v1_q, v2_q, v3_q;
  term_t      r1_q, r2_q, i1_q, i2_q;
  logic       l1_q, l2_q, l3_q;
  // stage 2 regs: aligned sums (wide form kept here), then stage 3 outputs
  logic        rsp_q, isp_q;
  logic [15:0] rspv_q, ispv_q;
  logic        rs_q, is_q;
  logic [8:0]  re_q, ie_q;
  logic [20:0] rsum_q, isum_q;
  logic [15:0] ro_q, io_q;

  logic adv;
  logic fr_mag, fr_neg, fi_mag, fi_neg;

  // whole pipe advances unless the output holds an item not taken
  assign adv = !v3_q || m_axis_tready;
  assign s_axis_tready = adv;

  // factor tables by phase
  always_comb begin
    fr_mag = !phase_q[0];
    fi_mag = phase_q[0];
    fr_neg = phase_q[0] ^ phase_q[1];
    fi_neg = phase_q[1];
  end

  always_comb begin
    phase_d = phase_q;
    if (s_axis_tvalid && adv && s_axis_tlast) begin
      phase_d = phase_q + 2'd1;
    end
  end

  // stage 1: decode and scale; real = ar*fr - ai*fi, imag = ar*fi + ai*fr
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (adv) begin
        v1_q <= s_axis_tvalid;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q <= scale_term(s_axis_tdata[15:0], fr_mag, fr_neg);
      r2_q <= scale_term(s_axis_tdata[31:16], fi_mag, !fi_neg);
      i1_q <= scale_term(s_axis_tdata[15:0], fi_mag, fi_neg);
      i2_q <= scale_term(s_axis_tdata[31:16], fr_mag, fr_neg);
      l1_q <= s_axis_tlast;
    end
  end

  // stage 2: align and add exactly (sticky keeps rounding correct)
  function automatic logic [47:0] add2(term_t p, term_t q);
    // returns {special, spec_val, sign, expo, sum21}
    term_t a, b;
    logic [8:0] d;
    logic [19:0] bigv, bv, sml;
    logic [20:0] s;
    logic sp;
    logic [15:0] sv;
    a = p;
    b = q;
    d = 9'd0;
    bigv = 20'd0;
    bv = 20'd0;
    sml = 20'd0;
    s = 21'd0;
    sp = 1'b0;
    sv = 16'd0;
    if (p.kind == KIND_NAN || q.kind == KIND_NAN) begin
      sp = 1'b1;
      sv = QnanBf16;
    end else if (p.kind == KIND_INF || q.kind == KIND_INF) begin
      sp = 1'b1;
      if (p.kind == KIND_INF && q.kind == KIND_INF && p.sign != q.sign) begin
        sv = QnanBf16;
      end else begin
        sv = {(p.kind == KIND_INF) ? p.sign : q.sign, 15'h7F80};
      end
    end else if (p.kind == KIND_ZERO && q.kind == KIND_ZERO) begin
      sp = 1'b1;
      sv = {p.sign & q.sign, 15'd0};
    end else begin
      if (p.kind == KIND_ZERO) begin
        a = q;
        b = p;
      end else if (q.kind == KIND_ZERO) begin
        a = p;
        b = q;
      end else if (p.expo > q.expo || (p.expo == q.expo && p.mant >= q.mant)) begin
        a = p;
        b = q;
      end else begin
        a = q;
        b = p;
      end
      bigv = {1'b0, a.mant, 11'd0};
      if (b.kind != KIND_ZERO) begin
        d = a.expo - b.expo;
        bv = {1'b0, b.mant, 11'd0};
        if (d > 9'd11) begin
          sml = 20'd1;
        end else begin
          sml = (bv >> d[3:0]) | {19'd0, ((bv & ~(20'hFFFFF << d[3:0])) != 20'd0)};
        end
      end
      if (a.sign == b.sign || b.kind == KIND_ZERO) begin
        s = {1'b0, bigv} + {1'b0, sml};
      end else begin
        s = {1'b0, bigv} - {1'b0, sml};
        if (s == 21'd0) begin
          sp = 1'b1;
          sv = 16'd0;
        end
      end
    end
    return {sp, sv, a.sign, a.expo, s};
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {rsp_q, rspv_q, rs_q, re_q, rsum_q} <= add2(r1_q, r2_q);
      {isp_q, ispv_q, is_q, ie_q, isum_q} <= add2(i1_q, i2_q);
      l2_q <= l1_q;
    end
  end

  // stage 3: normalize and round to bf16 (sum bits fit fp32, so one rounding)
  // sum value = s * 2^(expo - 145); hidden bit of a sits at bit 18
  function automatic logic [15:0] rnd(logic sp, logic [15:0] sv, logic sg,
                                      logic [8:0] ex, logic [20:0] s);
    logic [4:0] lead;
    logic [20:0] n;
    logic [7:0] keep;
    logic rb, st;
    logic [9:0] be;
    logic [8:0] k9;
    lead = 5'd0;
    for (int i = 0; i < 21; i++) begin
      if (s[i]) lead = 5'(i);
    end
    n = s << (5'd20 - lead);
    keep = n[20:13];
    rb = n[12];
    st = (n[11:0] != 12'd0);
    // biased = ex - 18 + lead (ex holds biased exponent of hidden bit)
    be = {1'b0, ex} + {5'd0, lead} - 10'd18;
    k9 = {1'b0, keep} + {8'd0, rb && (st || keep[0])};
    if (k9[8]) begin
      k9 = {1'b0, k9[8:1]};
      be = be + 10'd1;
    end
    if (sp) return sv;
    if (be[9] || be == 10'd0) return {sg, 15'd0};
    if (be >= 10'd255) return {sg, 15'h7F80};
    return {sg, be[7:0], k9[6:0]};
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ro_q <= rnd(rsp_q, rspv_q, rs_q, re_q, rsum_q);
      io_q <= rnd(isp_q, ispv_q, is_q, ie_q, isum_q);
      l3_q <= l2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {io_q, ro_q};
  assign m_axis_tlast  = l3_q;

endmodule

// ===== test/complex_bf16_rotating_scale_test.sv =====
// testbench for the rotating complex bf16 scaler: directed corners and a random stream against a bit-exact predictor
`timescale 1ns / 1ps

module complex_bf16_rotating_scale_test
  import cbrs_pkg::*;
();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  // one decoded term: value = mant * 2^expo
  typedef struct {
    kind_e       kind;
    bit          sign;
    bit [7:0]    mant;
    int          expo;
  } bf_term_t;

  typedef struct {
    bit [15:0] re;
    bit [15:0] im;
    bit        last;
  } sample_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  sample_t     pending_samples[$];
  sample_t     scaled_samples[$];
  bit [1:0]    tile_phase;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_left;
  bit          hold_for_drain;
  bit          stimulus_done;

  complex_bf16_rotating_scale u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bf_term_t unpack_bf16(bit [15:0] x, int mag, bit neg);
    bf_term_t t;
    t.sign = x[15] ^ neg;
    t.mant = 8'd0;
    t.expo = 0;
    if (x[14:7] == 8'hFF) begin
      t.kind = (x[6:0] != 0) ? KIND_NAN : KIND_INF;
    end else if (x[14:7] == 8'd0) begin
      t.kind = KIND_ZERO;  // subnormals flush to zero
    end else begin
      t.kind = KIND_FIN;
      t.mant = {1'b1, x[6:0]};
      t.expo = int'(x[14:7]) - 134 + mag;
    end
    return t;
  endfunction

  // round to fp32 (rne), flush tiny, then fp32 to bf16 (rne)
  function automatic bit [15:0] round_to_bf16(bit sign, bit [63:0] m, int eb);
    int        lead;
    int        sh;
    int        biased;
    bit [63:0] keep;
    bit [63:0] rem;
    bit [63:0] half;
    bit [31:0] bits;
    lead = 63;
    while (m[lead] == 1'b0) lead--;
    if (lead > 23) begin
      sh = lead - 23;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = m >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
    end else begin
      keep = m << (23 - lead);
    end
    biased = eb + lead + 127;
    if (keep[24]) begin
      keep >>= 1;
      biased++;
    end
    if (biased >= 255) return {sign, 15'h7F80};
    if (biased <= 0) return {sign, 15'h0000};
    bits = {sign, biased[7:0], keep[22:0]};
    bits = bits + 32'h7FFF + {31'd0, bits[16]};
    return bits[31:16];
  endfunction

  function automatic bit [15:0] sum_terms(bf_term_t p, bf_term_t q);
    bf_term_t  a;
    bf_term_t  b;
    bit [63:0] big;
    bit [63:0] sml;
    bit [63:0] v;
    bit [63:0] s;
    int        d;
    if (p.kind == KIND_NAN || q.kind == KIND_NAN) return QnanBf16;
    if (p.kind == KIND_INF || q.kind == KIND_INF) begin
      if (p.kind == KIND_INF && q.kind == KIND_INF && p.sign != q.sign) return QnanBf16;
      return {(p.kind == KIND_INF) ? p.sign : q.sign, 15'h7F80};
    end
    if (p.kind == KIND_ZERO && q.kind == KIND_ZERO) return {p.sign & q.sign, 15'd0};
    if (p.kind == KIND_ZERO) return round_to_bf16(q.sign, 64'(q.mant) << 40, q.expo - 40);
    if (q.kind == KIND_ZERO) return round_to_bf16(p.sign, 64'(p.mant) << 40, p.expo - 40);
    if (p.expo > q.expo || (p.expo == q.expo && p.mant >= q.mant)) begin
      a = p;
      b = q;
    end else begin
      a = q;
      b = p;
    end
    big = 64'(a.mant) << 40;
    d = a.expo - b.expo;
    if (d >= 50) begin
      sml = 64'd1;
    end else begin
      v = 64'(b.mant) << 40;
      sml = v >> d;
      if ((sml << d) != v) sml |= 64'd1;
    end
    if (a.sign == b.sign) begin
      s = big + sml;
    end else begin
      s = big - sml;
      if (s == 0) return 16'h0000;  // exact cancellation gives +0
    end
    return round_to_bf16(a.sign, s, a.expo - 40);
  endfunction

  // factor per phase: 2+j1, -1+j2, -2-j1, 1-j2 as log2 magnitude and sign
  function automatic sample_t scale_sample(sample_t x, bit [1:0] ph);
    bit [3:0] re_mag;
    bit [3:0] re_neg;
    bit [3:0] im_mag;
    bit [3:0] im_neg;
    sample_t  y;
    re_mag = 4'b0101;
    re_neg = 4'b0110;
    im_mag = 4'b1010;
    im_neg = 4'b1100;
    y.re = sum_terms(unpack_bf16(x.re, re_mag[ph], re_neg[ph]),
                     unpack_bf16(x.im, im_mag[ph], ~im_neg[ph]));
    y.im = sum_terms(unpack_bf16(x.re, im_mag[ph], im_neg[ph]),
                     unpack_bf16(x.im, re_mag[ph], re_neg[ph]));
    y.last = x.last;
    return y;
  endfunction

  function automatic bit [15:0] random_bf16();
    bit [15:0] x;
    x = 16'($urandom);
    case ($urandom_range(0, 9))
      0: x[14:7] = 8'hFF;
      1: x[14:7] = 8'h00;
      2: x[14:7] = 8'($urandom_range(250, 254));
      3: x[14:7] = 8'($urandom_range(1, 4));
      default: x[14:7] = 8'($urandom_range(110, 145));
    endcase
    return x;
  endfunction

  task automatic queue_sample(bit [15:0] re, bit [15:0] im, bit last);
    sample_t s;
    s.re = re;
    s.im = im;
    s.last = last;
    pending_samples.push_back(s);
  endtask

  // stimulus: directed corners over all four phases, then random tiles
  initial begin
    bit [15:0] corners[12];
    bit [15:0] m;
    corners = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'hFFFF,
                16'h0001, 16'h7F7F, 16'hFF7F, 16'h0080, 16'h3F80, 16'hBF80};
    for (int i = 0; i < 24; i++) begin
      queue_sample(corners[i % 12], corners[(i * 5 + 3) % 12], (i % 6) == 5);
    end
    // equal finite parts and opposite infinities in each phase
    for (int p = 0; p < 4; p++) begin
      queue_sample(16'h3F80, 16'h3F80, 1'b0);
      queue_sample(16'h7F80, 16'h7F80, 1'b0);
      queue_sample(16'h7F80, 16'hFF80, 1'b1);
    end
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        m = random_bf16();
        queue_sample(m, ($urandom_range(0, 1) != 0) ? m : (m ^ 16'h8000),
                     $urandom_range(0, 7) == 0);
      end else begin
        queue_sample(random_bf16(), random_bf16(), $urandom_range(0, 7) == 0);
      end
    end
  end

  // reset and the final verdict
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done && scaled_samples.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && scaled_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // driver: bursts with gaps, one full drain hold-off midway
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      hold_for_drain <= 1'b0;
      stimulus_done <= 1'b0;
    end else begin
      automatic bit      moved = s_axis_tvalid && s_axis_tready;
      automatic bit      hold = hold_for_drain;
      automatic sample_t s;
      if (moved) begin
        s.re = s_axis_tdata[15:0];
        s.im = s_axis_tdata[31:16];
        s.last = s_axis_tlast;
        scaled_samples.push_back(scale_sample(s, tile_phase));
        if (s.last) tile_phase <= tile_phase + 2'd1;
        if (pending_samples.size() == 600) hold = 1'b1;
      end
      if (s_axis_tvalid && !moved) begin
        // keep the item steady until taken
      end else if (hold && (scaled_samples.size() > 0 || moved)) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        stimulus_done <= 1'b1;
      end else begin
        s = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s.im, s.re};
        s_axis_tlast <= s.last;
        hold = 1'b0;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      hold_for_drain <= hold;
    end
  end

  // monitor: receiver stall pattern and field-by-field compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      mismatch_count <= 0;
    end else begin
      automatic sample_t want;
      // long ready stretches alternate with choppy stalls
      m_axis_tready <= (cycle_count[9:8] == 2'b01) ? ($urandom_range(0, 2) != 0) :
                       (cycle_count[9:8] == 2'b11) ? ($urandom_range(0, 4) == 0) : 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (scaled_samples.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected item %h", m_axis_tdata);
        end else begin
          want = scaled_samples.pop_front();
          if (m_axis_tdata[15:0] !== want.re || m_axis_tdata[31:16] !== want.im ||
              m_axis_tlast !== want.last) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display("mismatch: exp re %h im %h last %b, got re %h im %h last %b",
                       want.re, want.im, want.last,
                       m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
            end
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    tile_phase = 2'd0;
  end

endmodule
